### rtl/afc_pkg.sv
// Shared types and constants for the box-versus-frustum culling block.
`default_nettype none

package afc_pkg;

  // Plane tags travel at this width; up to eight planes fit.
  localparam int unsigned PlaneIdxW = 3;
  localparam int unsigned NormW     = 18;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned OffsetW   = 64;
  localparam int unsigned ProdW     = NormW + CoordW;
  localparam int unsigned DotW      = ProdW + 2;
  localparam int unsigned DistW     = OffsetW + 1;

  // Item kinds on the input tuser.
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncTest  = 1'b1;

  typedef struct packed {
    logic signed [OffsetW-1:0] offset;
    logic signed [NormW-1:0]   nz;
    logic signed [NormW-1:0]   ny;
    logic signed [NormW-1:0]   nx;
  } plane_t;

  typedef struct packed {
    logic signed [CoordW-1:0] max_z;
    logic signed [CoordW-1:0] max_y;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] min_y;
    logic signed [CoordW-1:0] min_x;
  } box_t;

  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic [PlaneIdxW-1:0] idx;
  } eval_res_t;

endpackage

`default_nettype wire

### rtl/afc_plane_mem.sv
// Plane memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module afc_plane_mem #(
  parameter int unsigned Depth = 6,
  parameter int unsigned AddrW = 3
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  we_i,
  input  wire [AddrW-1:0]      waddr_i,
  input  afc_pkg::plane_t      wdata_i,
  input  wire                  re_i,
  input  wire [AddrW-1:0]      raddr_i,
  output afc_pkg::plane_t      rdata_o
);
  import afc_pkg::*;

  plane_t             mem [Depth];
  logic [Depth-1:0]   valid_q;
  plane_t             rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // A plane never written reads as all zero.
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

### rtl/afc_plane_eval.sv
// Three-stage plane test: corner select and products, dot sum, sign of dot plus offset.
`default_nettype none

module afc_plane_eval (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               valid_i,
  input  wire [afc_pkg::PlaneIdxW-1:0]      idx_i,
  input  afc_pkg::plane_t                   plane_i,
  input  afc_pkg::box_t                     box_i,
  output afc_pkg::eval_res_t                res_o
);
  import afc_pkg::*;

  logic                      vld1_q, vld2_q, vld3_q;
  logic [PlaneIdxW-1:0]      idx1_q, idx2_q, idx3_q;
  logic signed [ProdW-1:0]   px_q, py_q, pz_q;
  logic signed [OffsetW-1:0] off1_q, off2_q;
  logic signed [DotW-1:0]    dot_q;
  logic                      neg_q;
  logic signed [CoordW-1:0]  cx, cy, cz;
  logic signed [DistW-1:0]   dist_sum;

  // Positive vertex: max corner where the normal is at or above zero.
  always_comb begin
    cx = plane_i.nx[NormW-1] ? box_i.min_x : box_i.max_x;
    cy = plane_i.ny[NormW-1] ? box_i.min_y : box_i.max_y;
    cz = plane_i.nz[NormW-1] ? box_i.min_z : box_i.max_z;
  end

  assign dist_sum = DistW'(dot_q) + DistW'(off2_q);

  always_ff @(posedge clk_i) begin
    px_q   <= plane_i.nx * cx;
    py_q   <= plane_i.ny * cy;
    pz_q   <= plane_i.nz * cz;
    off1_q <= plane_i.offset;
    idx1_q <= idx_i;
    dot_q  <= DotW'(px_q) + DotW'(py_q) + DotW'(pz_q);
    off2_q <= off1_q;
    idx2_q <= idx1_q;
    neg_q  <= dist_sum[DistW-1];
    idx3_q <= idx2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  assign res_o = '{valid: vld3_q, neg: neg_q, idx: idx3_q};

endmodule

`default_nettype wire

### rtl/aabb_frustum_cull_test.sv
// Top level of the box-versus-frustum culling block: sequencer and stream ports.
`default_nettype none

// Holds PLANE_COUNT frustum planes in a small plane memory; after reset every
// plane is zero and every box is visible. An item with tuser 0 writes the plane
// named by plane_index (indexes at or above PLANE_COUNT are dropped) and gives
// no result. An item with tuser 1 tests a box: the sequencer reads one plane
// per cycle from the single memory read port and pipes it through a three-stage
// test unit; the block takes no new item until the result enters the output
// register. The result reports visibility and the first plane with a negative
// distance (PLANE_COUNT masked to three bits if none). The next item is accepted
// while a result waits.
module aabb_frustum_cull_test #(
  parameter int unsigned PLANE_COUNT = 6
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: plane_index[3], normal_x[18], normal_y[18], normal_z[18],
  // plane_offset[64], box_min_x/y/z[32 each], box_max_x/y/z[32 each], zero pad
  input  wire  [319:0] s_axis_tdata,
  // tuser: func
  input  wire          s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // tdata from bit 0: visible[1], first_rejecting_plane[3], zero pad
  output logic [7:0]   m_axis_tdata
);
  import afc_pkg::*;

  localparam int unsigned AddrW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(PLANE_COUNT - 1);
  localparam logic [PlaneIdxW-1:0] LastIdx = PlaneIdxW'(PLANE_COUNT - 1);
  localparam logic [PlaneIdxW-1:0] NoneCode = PlaneIdxW'(PLANE_COUNT);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [AddrW-1:0]     cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic [PlaneIdxW-1:0] rej_q, rej_d;
  logic                 rd_vld_q;
  logic [AddrW-1:0]     rd_idx_q;
  box_t                 box_q;
  logic                 out_vld_q, out_vld_d;
  logic                 vis_q;
  logic [PlaneIdxW-1:0] frp_q;

  logic                 in_acc;
  logic [2:0]           in_idx;
  plane_t               in_plane;
  box_t                 in_box;
  logic                 mem_we, mem_re;
  plane_t               mem_rdata;
  eval_res_t            eval_res;
  logic                 load_out;

  assign in_idx         = s_axis_tdata[2:0];
  assign in_plane.nx    = s_axis_tdata[20:3];
  assign in_plane.ny    = s_axis_tdata[38:21];
  assign in_plane.nz    = s_axis_tdata[56:39];
  assign in_plane.offset = s_axis_tdata[120:57];
  assign in_box.min_x   = s_axis_tdata[152:121];
  assign in_box.min_y   = s_axis_tdata[184:153];
  assign in_box.min_z   = s_axis_tdata[216:185];
  assign in_box.max_x   = s_axis_tdata[248:217];
  assign in_box.max_y   = s_axis_tdata[280:249];
  assign in_box.max_z   = s_axis_tdata[312:281];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign mem_we        = in_acc && (s_axis_tuser == FuncWrite) &&
                         ({1'b0, in_idx} < 4'(PLANE_COUNT));
  assign mem_re        = (state_q == StRun);
  assign load_out      = (state_q == StDone) && (!out_vld_q || m_axis_tready);

  afc_plane_mem #(
    .Depth(PLANE_COUNT),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (mem_we),
    .waddr_i(in_idx[AddrW-1:0]),
    .wdata_i(in_plane),
    .re_i   (mem_re),
    .raddr_i(cnt_q),
    .rdata_o(mem_rdata)
  );

  afc_plane_eval u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(rd_vld_q),
    .idx_i  (PlaneIdxW'(rd_idx_q)),
    .plane_i(mem_rdata),
    .box_i  (box_q),
    .res_o  (eval_res)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    rej_d     = rej_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_acc && (s_axis_tuser == FuncTest)) begin
          state_d = StRun;
          cnt_d   = '0;
          found_d = 1'b0;
        end
      end
      StRun: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastAddr) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (eval_res.valid && (eval_res.idx == LastIdx)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
    // Keep the first rejecting plane; results arrive in plane order.
    if (eval_res.valid && eval_res.neg && !found_q) begin
      found_d = 1'b1;
      rej_d   = eval_res.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      rej_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      rej_q     <= rej_d;
      rd_vld_q  <= mem_re;
      rd_idx_q  <= cnt_q;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == FuncTest)) begin
      box_q <= in_box;
    end
    if (load_out) begin
      vis_q <= !found_q;
      frp_q <= found_q ? rej_q : NoneCode;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, frp_q, vis_q};

  a_eval_in_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_res.valid |-> (state_q == StRun || state_q == StDrain))
    else $error("plane result outside a box test");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("plane write during a box test");

  a_rej_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> ({1'b0, rej_q} < 4'(PLANE_COUNT)))
    else $error("rejecting plane index out of range");

  a_done_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain && state_d == StDone) |=> (state_q == StDone))
    else $error("sequencer skipped result load");

endmodule

`default_nettype wire
